@@ rtl/bnwq_pkg.sv @@
// Shared types, constants and helpers of the buffered NVM write queue.
`default_nettype none
package bnwq_pkg;

  localparam int RING_BYTES   = 512;
  localparam int MEMORY_BYTES = 1024;
  localparam int HDR_BYTES    = 4;
  localparam int RING_AW      = $clog2(RING_BYTES);
  localparam int FREE_W       = $clog2(RING_BYTES + 1);
  localparam int CMP_W        = FREE_W + 1;

  localparam logic [10:0] ERASE_LEN  = 11'(MEMORY_BYTES & 'h7FF);
  localparam logic [7:0]  ERASE_FILL = 8'hFF;

  localparam logic [2:0] OPC_REPEAT    = 3'd0;
  localparam logic [2:0] OPC_DATA_HDR  = 3'd1;
  localparam logic [2:0] OPC_DATA_BYTE = 3'd2;
  localparam logic [2:0] OPC_TICK      = 3'd3;
  localparam logic [2:0] OPC_ERASE     = 3'd4;

  typedef enum logic [2:0] {
    OP_REPEAT,
    OP_DATA_HDR,
    OP_DATA_BYTE,
    OP_TICK,
    OP_ERASE,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e         kind;
    logic [9:0]  address;
    logic [7:0]  value;
    logic [10:0] count;
    logic        busy;
    logic [7:0]  stored;
  } item_t;

  typedef struct packed {
    logic        accepted;
    logic        write_valid;
    logic [9:0]  write_address;
    logic [7:0]  write_data;
    logic [9:0]  pending_address;
    logic [9:0]  free_bytes;
    logic        done;
  } res_t;

  // header layout: addr lo, len lo, fill, {rep, len hi, addr hi}
  function automatic logic [3:0][7:0] hdr_pack(input logic [9:0] addr,
                                               input logic [10:0] len,
                                               input logic [7:0] fill,
                                               input logic rep);
    logic [3:0][7:0] h;
    h[0] = addr[7:0];
    h[1] = len[7:0];
    h[2] = fill;
    h[3] = {2'b00, rep, len[10:8], addr[9:8]};
    return h;
  endfunction

endpackage
`default_nettype wire

@@ rtl/buffered_nvm_write_queue_top.sv @@
// Top level of the buffered NVM write queue: front decoder, item queue, back end.
//
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_stall_o | op, address, value, count, nvm_busy, stored_byte
//  out     | output    | out_valid_o/out_stall_i | accepted, write_*, pending_address,
//          |           |                         | free_bytes, done_res
//
// Back end: a simple item goes straight to the result state, a byte drain passes S_POPD,
// an enqueue or erase writes four header bytes on the single ring port in S_PUSH, and a
// header load does four registered ring reads in S_POPH, then takes the last in S_LOADH.
// Reset clears all control state; the ring contents are left as they are.
// The two-entry front queue keeps taking items, until both entries are full, while the
// back end works or a result waits in the output register.
`default_nettype none
module buffered_nvm_write_queue_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [2:0]  op_i,
  input  wire  [9:0]  address_i,
  input  wire  [7:0]  value_i,
  input  wire  [10:0] count_i,
  input  wire         nvm_busy_i,
  input  wire  [7:0]  stored_byte_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic        accepted_o,
  output logic        write_valid_o,
  output logic [9:0]  write_address_o,
  output logic [7:0]  write_data_o,
  output logic [9:0]  pending_address_o,
  output logic [9:0]  free_bytes_o,
  output logic        done_res_o
);
  import bnwq_pkg::*;

  logic  q_valid, q_take;
  item_t q_item;
  res_t  res;

  bnwq_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .address_i     (address_i),
    .value_i       (value_i),
    .count_i       (count_i),
    .nvm_busy_i    (nvm_busy_i),
    .stored_byte_i (stored_byte_i),
    .q_valid_o     (q_valid),
    .q_item_o      (q_item),
    .q_take_i      (q_take)
  );

  bnwq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_take_o    (q_take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign accepted_o        = res.accepted;
  assign write_valid_o     = res.write_valid;
  assign write_address_o   = res.write_address;
  assign write_data_o      = res.write_data;
  assign pending_address_o = res.pending_address;
  assign free_bytes_o      = res.free_bytes;
  assign done_res_o        = res.done;

  a_write_not_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_valid_o |-> !accepted_o)
    else $error("write started by an item that was also taken into the ring");

  a_done_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> free_bytes_o == 10'(RING_BYTES))
    else $error("done reported with a non-empty ring");

  a_free_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> free_bytes_o <= 10'(RING_BYTES))
    else $error("free byte count beyond ring size");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_valid_o |-> write_address_o == 10'd0 && write_data_o == 8'd0)
    else $error("write fields not cleared without a write");

endmodule
`default_nettype wire

@@ rtl/bnwq_front.sv @@
// Front end: takes items, decodes the opcode and queues them for the back end.
`default_nettype none
module bnwq_front (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  wire  [2:0]        op_i,
  input  wire  [9:0]        address_i,
  input  wire  [7:0]        value_i,
  input  wire  [10:0]       count_i,
  input  wire               nvm_busy_i,
  input  wire  [7:0]        stored_byte_i,
  output logic              q_valid_o,
  output bnwq_pkg::item_t   q_item_o,
  input  wire               q_take_i
);
  import bnwq_pkg::*;

  item_t      fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  item_t      item_d;

  always_comb begin
    item_d.address = address_i;
    item_d.value   = value_i;
    item_d.count   = count_i;
    item_d.busy    = nvm_busy_i;
    item_d.stored  = stored_byte_i;
    unique case (op_i)
      OPC_REPEAT:    item_d.kind = OP_REPEAT;
      OPC_DATA_HDR:  item_d.kind = OP_DATA_HDR;
      OPC_DATA_BYTE: item_d.kind = OP_DATA_BYTE;
      OPC_TICK:      item_d.kind = OP_TICK;
      OPC_ERASE:     item_d.kind = OP_ERASE;
      default:       item_d.kind = OP_NOP;
    endcase
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = fifo_q[rd_ptr_q];
  assign pop        = q_valid_o && q_take_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= item_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/bnwq_back.sv @@
// Back end: ring memory, run state and drain sequencer with the result register.
`default_nettype none
module bnwq_back (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               q_valid_i,
  input  bnwq_pkg::item_t   q_item_i,
  output logic              q_take_o,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output bnwq_pkg::res_t    res_o
);
  import bnwq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_POPH,
    S_LOADH,
    S_POPD,
    S_RES
  } state_e;

  state_e             state_q;
  logic [7:0]         ring_mem [RING_BYTES];
  logic [7:0]         rdata_q;
  logic               mem_we;
  logic [RING_AW-1:0] mem_addr;
  logic [7:0]         mem_wdata;

  logic [RING_AW-1:0] head_q, tail_q;
  logic [FREE_W-1:0]  free_q;
  logic [9:0]         run_addr_q;
  logic [10:0]        run_rem_q;
  logic               run_rep_q;
  logic [7:0]         run_fill_q;
  logic [7:0]         data_exp_q;
  logic               dropping_q;
  logic [1:0]         idx_q;
  logic [3:0][7:0]    hdr_q;
  item_t              cur_q;
  logic               acc_q, wv_q;
  logic [9:0]         wa_q;
  logic [7:0]         wd_q;
  logic               out_valid_q;
  res_t               out_q;

  logic [7:0]         len;
  logic               data_fits, hdr_avail, free_nz, free_nf;

  assign len       = q_item_i.count[7:0];
  assign data_fits = (CMP_W'(len) + CMP_W'(HDR_BYTES)) <= CMP_W'(free_q);
  assign hdr_avail = (CMP_W'(free_q) + CMP_W'(HDR_BYTES)) <= CMP_W'(RING_BYTES);
  assign free_nz   = (free_q != '0);
  assign free_nf   = (free_q != FREE_W'(RING_BYTES));
  assign q_take_o  = (state_q == S_IDLE);

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = tail_q;
    mem_wdata = hdr_q[idx_q];
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i && q_item_i.kind == OP_DATA_BYTE && data_exp_q != 8'd0
            && !dropping_q) begin
          mem_we    = 1'b1;
          mem_addr  = head_q;
          mem_wdata = q_item_i.value;
        end
      end
      S_PUSH: begin
        mem_we   = 1'b1;
        mem_addr = head_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[mem_addr] <= mem_wdata;
    end
    rdata_q <= ring_mem[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      free_q      <= FREE_W'(RING_BYTES);
      run_addr_q  <= '0;
      run_rem_q   <= '0;
      run_rep_q   <= 1'b0;
      run_fill_q  <= '0;
      data_exp_q  <= '0;
      dropping_q  <= 1'b0;
      idx_q       <= '0;
      hdr_q       <= '0;
      cur_q       <= '0;
      acc_q       <= 1'b0;
      wv_q        <= 1'b0;
      wa_q        <= '0;
      wd_q        <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            cur_q   <= q_item_i;
            acc_q   <= 1'b0;
            wv_q    <= 1'b0;
            wa_q    <= '0;
            wd_q    <= '0;
            idx_q   <= '0;
            state_q <= S_RES;
            case (q_item_i.kind)
              OP_REPEAT: begin
                if (data_exp_q == 8'd0 && free_q >= FREE_W'(HDR_BYTES)) begin
                  hdr_q   <= hdr_pack(q_item_i.address, q_item_i.count,
                                      q_item_i.value, 1'b1);
                  acc_q   <= 1'b1;
                  state_q <= S_PUSH;
                end
              end
              OP_DATA_HDR: begin
                if (data_exp_q == 8'd0) begin
                  if (data_fits) begin
                    hdr_q      <= hdr_pack(q_item_i.address, {3'b000, len}, 8'h00, 1'b0);
                    acc_q      <= 1'b1;
                    dropping_q <= 1'b0;
                    state_q    <= S_PUSH;
                  end else begin
                    dropping_q <= (len != 8'd0);
                  end
                  data_exp_q <= len;
                end
              end
              OP_DATA_BYTE: begin
                if (data_exp_q != 8'd0) begin
                  if (!dropping_q) begin
                    head_q <= head_q + RING_AW'(1);
                    if (free_nz) begin
                      free_q <= free_q - FREE_W'(1);
                    end
                    acc_q <= 1'b1;
                  end
                  data_exp_q <= data_exp_q - 8'd1;
                  if (data_exp_q == 8'd1) begin
                    dropping_q <= 1'b0;
                  end
                end
              end
              OP_TICK: begin
                if (!q_item_i.busy && data_exp_q == 8'd0) begin
                  if (run_rem_q != 11'd0) begin
                    if (run_rep_q) begin
                      if (q_item_i.stored != run_fill_q) begin
                        wv_q <= 1'b1;
                        wa_q <= run_addr_q;
                        wd_q <= run_fill_q;
                      end
                      run_addr_q <= run_addr_q + 10'd1;
                      run_rem_q  <= run_rem_q - 11'd1;
                    end else begin
                      tail_q <= tail_q + RING_AW'(1);
                      if (free_nf) begin
                        free_q <= free_q + FREE_W'(1);
                      end
                      state_q <= S_POPD;
                    end
                  end else if (hdr_avail) begin
                    state_q <= S_POPH;
                  end
                end
              end
              OP_ERASE: begin
                head_q     <= '0;
                tail_q     <= '0;
                free_q     <= FREE_W'(RING_BYTES);
                run_addr_q <= '0;
                run_rem_q  <= '0;
                run_rep_q  <= 1'b0;
                run_fill_q <= '0;
                data_exp_q <= '0;
                dropping_q <= 1'b0;
                hdr_q      <= hdr_pack(10'd0, ERASE_LEN, ERASE_FILL, 1'b1);
                acc_q      <= 1'b1;
                state_q    <= S_PUSH;
              end
              default: ;
            endcase
          end
        end
        S_PUSH: begin
          head_q <= head_q + RING_AW'(1);
          if (free_nz) begin
            free_q <= free_q - FREE_W'(1);
          end
          idx_q <= idx_q + 2'd1;
          if (idx_q == 2'd3) begin
            state_q <= S_RES;
          end
        end
        S_POPH: begin
          tail_q <= tail_q + RING_AW'(1);
          if (free_nf) begin
            free_q <= free_q + FREE_W'(1);
          end
          if (idx_q != 2'd0) begin
            hdr_q[idx_q - 2'd1] <= rdata_q;
          end
          idx_q <= idx_q + 2'd1;
          if (idx_q == 2'd3) begin
            state_q <= S_LOADH;
          end
        end
        S_LOADH: begin
          run_addr_q <= {rdata_q[1:0], hdr_q[0]};
          run_rem_q  <= {rdata_q[4:2], hdr_q[1]};
          run_rep_q  <= rdata_q[5];
          run_fill_q <= hdr_q[2];
          state_q    <= S_RES;
        end
        S_POPD: begin
          if (cur_q.stored != rdata_q) begin
            wv_q <= 1'b1;
            wa_q <= run_addr_q;
            wd_q <= rdata_q;
          end
          run_addr_q <= run_addr_q + 10'd1;
          run_rem_q  <= run_rem_q - 11'd1;
          state_q    <= S_RES;
        end
        S_RES: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q           <= 1'b1;
            out_q.accepted        <= acc_q;
            out_q.write_valid     <= wv_q;
            out_q.write_address   <= wa_q;
            out_q.write_data      <= wd_q;
            out_q.pending_address <= run_addr_q;
            out_q.free_bytes      <= 10'(free_q);
            out_q.done            <= !free_nf && !cur_q.busy;
            state_q               <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule
`default_nettype wire

@@ tb/buffered_nvm_write_queue_top_tb.sv @@
// Self-checking testbench of the buffered NVM write queue: directed, fill, pressure, random traffic.
module buffered_nvm_write_queue_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bnwq_pkg::*;

  localparam logic [2:0] OPC_UNUSED_LO = 3'd5;
  localparam logic [2:0] OPC_UNUSED_HI = 3'd7;
  localparam int unsigned RANDOM_ITEMS = 1050;
  localparam int unsigned STEADY_ITEMS = 200;
  localparam int unsigned SETTLE_CYCLES = 20;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  op_i = OPC_TICK;
  logic [9:0]  address_i = '0;
  logic [7:0]  value_i = '0;
  logic [10:0] count_i = '0;
  logic        nvm_busy_i = 1'b0;
  logic [7:0]  stored_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        accepted_o;
  logic        write_valid_o;
  logic [9:0]  write_address_o;
  logic [7:0]  write_data_o;
  logic [9:0]  pending_address_o;
  logic [9:0]  free_bytes_o;
  logic        done_res_o;

  buffered_nvm_write_queue_top i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .op_i              (op_i),
    .address_i         (address_i),
    .value_i           (value_i),
    .count_i           (count_i),
    .nvm_busy_i        (nvm_busy_i),
    .stored_byte_i     (stored_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .accepted_o        (accepted_o),
    .write_valid_o     (write_valid_o),
    .write_address_o   (write_address_o),
    .write_data_o      (write_data_o),
    .pending_address_o (pending_address_o),
    .free_bytes_o      (free_bytes_o),
    .done_res_o        (done_res_o)
  );

  // shadow of the write queue
  logic [7:0]         q_ring [RING_BYTES];
  logic [RING_AW-1:0] q_head = '0;
  logic [RING_AW-1:0] q_tail = '0;
  int unsigned        q_free = RING_BYTES;
  logic [9:0]         q_run_addr = '0;
  logic [10:0]        q_run_left = '0;
  logic               q_run_rep = 1'b0;
  logic [7:0]         q_run_fill = '0;
  logic [7:0]         q_data_left = '0;
  logic               q_dropping = 1'b0;
  logic [7:0]         nvm_image [MEMORY_BYTES];

  res_t        predicted_results [$];
  int unsigned fail_count = 0;
  bit          idle_en = 1'b1;
  int unsigned hold_req = 0;

  function automatic void ring_push(logic [7:0] b);
    q_ring[q_head] = b;
    q_head++;
    if (q_free > 0) q_free--;
  endfunction

  function automatic logic [7:0] ring_pop();
    logic [7:0] b;
    b = q_ring[q_tail];
    q_tail++;
    if (q_free < RING_BYTES) q_free++;
    return b;
  endfunction

  function automatic void push_run_header(logic [9:0] addr, logic [10:0] len, logic [7:0] fill,
                                          logic rep);
    ring_push(addr[7:0]);
    ring_push(len[7:0]);
    ring_push(fill);
    ring_push({2'b00, rep, len[10:8], addr[9:8]});
  endfunction

  function automatic res_t advance_write_queue(logic [2:0] op, logic [9:0] addr, logic [7:0] val,
                                               logic [10:0] cnt, logic busy, logic [7:0] stored);
    res_t       r;
    logic [7:0] b, h0, h1, h2, h3;
    r = '0;
    case (op)
      OPC_REPEAT: begin
        if (q_data_left == 0 && q_free >= HDR_BYTES) begin
          push_run_header(addr, cnt, val, 1'b1);
          r.accepted = 1'b1;
        end
      end
      OPC_DATA_HDR: begin
        if (q_data_left == 0) begin
          if (cnt[7:0] + HDR_BYTES <= q_free) begin
            push_run_header(addr, {3'b000, cnt[7:0]}, 8'h00, 1'b0);
            r.accepted = 1'b1;
            q_dropping = 1'b0;
          end else begin
            q_dropping = (cnt[7:0] != 0);
          end
          q_data_left = cnt[7:0];
        end
      end
      OPC_DATA_BYTE: begin
        if (q_data_left != 0) begin
          if (!q_dropping) begin
            ring_push(val);
            r.accepted = 1'b1;
          end
          q_data_left--;
          if (q_data_left == 0) q_dropping = 1'b0;
        end
      end
      OPC_TICK: begin
        if (!busy && q_data_left == 0) begin
          if (q_run_left != 0) begin
            b = q_run_rep ? q_run_fill : ring_pop();
            if (stored != b) begin
              r.write_valid = 1'b1;
              r.write_address = q_run_addr;
              r.write_data = b;
              nvm_image[q_run_addr] = b;
            end
            q_run_addr++;
            q_run_left--;
          end else if (q_free + HDR_BYTES <= RING_BYTES) begin
            h0 = ring_pop();
            h1 = ring_pop();
            h2 = ring_pop();
            h3 = ring_pop();
            q_run_addr = {h3[1:0], h0};
            q_run_left = {h3[4:2], h1};
            q_run_rep = h3[5];
            q_run_fill = h2;
          end
        end
      end
      OPC_ERASE: begin
        q_head = '0;
        q_tail = '0;
        q_free = RING_BYTES;
        q_run_addr = '0;
        q_run_left = '0;
        q_run_rep = 1'b0;
        q_run_fill = '0;
        q_data_left = '0;
        q_dropping = 1'b0;
        push_run_header(10'd0, ERASE_LEN, ERASE_FILL, 1'b1);
        r.accepted = 1'b1;
      end
      default: ;
    endcase
    r.pending_address = q_run_addr;
    r.free_bytes = 10'(q_free);
    r.done = (q_free == RING_BYTES) && !busy;
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic send_item(logic [2:0] op, logic [9:0] addr, logic [7:0] val, logic [10:0] cnt,
                           logic busy, logic [7:0] stored);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= op;
    address_i     <= addr;
    value_i       <= val;
    count_i       <= cnt;
    nvm_busy_i    <= busy;
    stored_byte_i <= stored;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predicted_results.push_back(advance_write_queue(op, addr, val, cnt, busy, stored));
  endtask

  // stored byte mostly mirrors the memory so that unchanged bytes get skipped
  task automatic send_tick(logic busy);
    send_item(OPC_TICK, 10'($urandom), 8'($urandom), 11'($urandom), busy,
              ($urandom_range(0, 3) != 0) ? nvm_image[q_run_addr] : 8'($urandom));
  endtask

  task automatic send_data_bytes(int unsigned n);
    repeat (n) begin
      send_item(OPC_DATA_BYTE, 10'($urandom), 8'($urandom), 11'($urandom), 1'($urandom),
                8'($urandom));
    end
  endtask

  task automatic send_noise();
    logic [2:0] op;
    if (q_data_left == 0) begin
      op = $urandom_range(0, 1) ? OPC_DATA_BYTE : 3'($urandom_range(OPC_UNUSED_LO, OPC_UNUSED_HI));
    end else begin
      case ($urandom_range(0, 3))
        0: op = OPC_REPEAT;
        1: op = OPC_DATA_HDR;
        2: op = OPC_TICK;
        default: op = 3'($urandom_range(OPC_UNUSED_LO, OPC_UNUSED_HI));
      endcase
    end
    send_item(op, 10'($urandom), 8'($urandom), 11'($urandom), 1'($urandom), 8'($urandom));
  endtask

  task automatic drain_queue();
    while (q_data_left != 0) send_data_bytes(1);
    while (q_free != RING_BYTES || q_run_left != 0) send_tick($urandom_range(0, 7) == 0);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (predicted_results.size() != 0);
  endtask

  task automatic random_traffic(int unsigned n);
    int unsigned sent;
    int unsigned pick;
    int unsigned len;
    logic [10:0] run_len;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 199);
      if (pick < 56) begin
        run_len = ($urandom_range(0, 39) == 0) ? 11'($urandom) : 11'($urandom_range(0, 8));
        send_item(OPC_REPEAT, 10'($urandom), 8'($urandom), run_len, 1'($urandom), 8'($urandom));
        sent++;
      end else if (pick < 100) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
        send_item(OPC_DATA_HDR, 10'($urandom), 8'($urandom), {3'($urandom), 8'(len)},
                  1'($urandom), 8'($urandom));
        sent++;
        // now and then the run is cut short
        if ($urandom_range(0, 14) == 0) len = $urandom_range(0, len);
        repeat (len) begin
          if ($urandom_range(0, 11) == 0) send_noise();
          send_data_bytes(1);
          sent++;
        end
      end else if (pick < 190) begin
        repeat ($urandom_range(1, 10)) begin
          send_tick($urandom_range(0, 4) == 0);
          sent++;
        end
      end else if (pick < 191) begin
        send_item(OPC_ERASE, 10'($urandom), 8'($urandom), 11'($urandom), 1'($urandom),
                  8'($urandom));
        sent++;
      end else begin
        send_noise();
      end
    end
  endtask

  task automatic test_directed();
    send_item(OPC_TICK,      10'd0,    8'h00, 11'd0,    1'b0, 8'h00);
    send_item(OPC_TICK,      10'd1023, 8'hFF, 11'd2047, 1'b1, 8'hFF);
    send_item(OPC_REPEAT,    10'd1022, 8'hA5, 11'd3,    1'b1, 8'h00);
    // length taken from the low byte only
    send_item(OPC_DATA_HDR,  10'd1023, 8'h00, 11'h702,  1'b0, 8'h00);
    send_item(OPC_REPEAT,    10'd5,    8'h11, 11'd4,    1'b0, 8'h00);
    send_item(OPC_DATA_HDR,  10'd6,    8'h22, 11'd9,    1'b0, 8'h00);
    send_item(OPC_TICK,      10'd0,    8'h00, 11'd0,    1'b0, 8'h00);
    send_item(OPC_DATA_BYTE, 10'd0,    8'h00, 11'd0,    1'b0, 8'h00);
    send_item(OPC_DATA_BYTE, 10'd0,    8'hFF, 11'd0,    1'b0, 8'h00);
    send_item(OPC_DATA_BYTE, 10'd0,    8'h77, 11'd0,    1'b0, 8'h00);
    send_item(OPC_UNUSED_LO, 10'd0,    8'h00, 11'd0,    1'b0, 8'h00);
    send_item(OPC_UNUSED_LO + 3'd1, 10'd1023, 8'hFF, 11'd2047, 1'b1, 8'hFF);
    send_item(OPC_UNUSED_HI, 10'd0,    8'h00, 11'd0,    1'b0, 8'h00);
    // repeat run: load, skip, busy, write, write across the address wrap
    send_item(OPC_TICK,      10'd0,    8'h00, 11'd0,    1'b0, 8'hA5);
    send_item(OPC_TICK,      10'd0,    8'h00, 11'd0,    1'b0, 8'hA5);
    send_item(OPC_TICK,      10'd0,    8'h00, 11'd0,    1'b1, 8'h00);
    send_item(OPC_TICK,      10'd0,    8'h00, 11'd0,    1'b0, 8'h00);
    send_item(OPC_TICK,      10'd0,    8'h00, 11'd0,    1'b0, 8'h5A);
    send_item(OPC_TICK,      10'd0,    8'h00, 11'd0,    1'b0, 8'h00);
    send_item(OPC_TICK,      10'd0,    8'h00, 11'd0,    1'b0, 8'hFF);
    send_item(OPC_TICK,      10'd0,    8'h00, 11'd0,    1'b0, 8'hFF);
    send_item(OPC_DATA_HDR,  10'd300,  8'h00, 11'd0,    1'b0, 8'h00);
    send_item(OPC_TICK,      10'd0,    8'h00, 11'd0,    1'b0, 8'h00);
    send_item(OPC_TICK,      10'd0,    8'h00, 11'd0,    1'b0, 8'h00);
    send_item(OPC_REPEAT,    10'd0,    8'h00, 11'd2047, 1'b0, 8'h00);
    send_item(OPC_DATA_HDR,  10'd512,  8'h00, 11'd2,    1'b0, 8'h00);
    send_item(OPC_DATA_BYTE, 10'd0,    8'h3C, 11'd0,    1'b0, 8'h00);
    // erase in the middle of a data run
    send_item(OPC_ERASE,     10'd1023, 8'h00, 11'd2047, 1'b1, 8'hFF);
  endtask

  task automatic test_no_room();
    int unsigned len;
    drain_queue();
    while (q_free >= 2 * HDR_BYTES) begin
      send_item(OPC_REPEAT, 10'($urandom), 8'($urandom), 11'($urandom_range(0, 3)),
                1'($urandom), 8'($urandom));
    end
    len = q_free - HDR_BYTES + 1;
    send_item(OPC_DATA_HDR, 10'($urandom), 8'($urandom), {3'b101, 8'(len)}, 1'b0, 8'($urandom));
    send_data_bytes(len);
    len = q_free - HDR_BYTES;
    send_item(OPC_DATA_HDR, 10'($urandom), 8'($urandom), 11'(len), 1'b0, 8'($urandom));
    send_data_bytes(len);
    send_item(OPC_REPEAT, 10'($urandom), 8'($urandom), 11'd1, 1'b0, 8'($urandom));
    send_item(OPC_DATA_HDR, 10'($urandom), 8'($urandom), 11'h100, 1'b0, 8'($urandom));
    drain_queue();
  endtask

  task automatic test_backpressure();
    idle_en = 1'b0;
    hold_req <= 300;
    random_traffic(40);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    idle_en = 1'b1;
    random_traffic(RANDOM_ITEMS - STEADY_ITEMS);
  endtask

  task automatic test_steady_stream();
    idle_en = 1'b0;
    random_traffic(STEADY_ITEMS);
  endtask

  initial begin
    foreach (nvm_image[i]) nvm_image[i] = 8'($urandom);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_no_room();
    test_directed();
    test_backpressure();
    test_random_traffic();
    test_steady_stream();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // receiver: random stall bursts, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_req) @(posedge clk_i);
        hold_req <= 0;
        out_stall_i <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (predicted_results.size() == 0) begin
        $error("result with no item outstanding");
        fail_count++;
      end else begin
        want = predicted_results.pop_front();
        check_field("accepted", 32'(want.accepted), 32'(accepted_o));
        check_field("write_valid", 32'(want.write_valid), 32'(write_valid_o));
        check_field("write_address", 32'(want.write_address), 32'(write_address_o));
        check_field("write_data", 32'(want.write_data), 32'(write_data_o));
        check_field("pending_address", 32'(want.pending_address), 32'(pending_address_o));
        check_field("free_bytes", 32'(want.free_bytes), 32'(free_bytes_o));
        check_field("done_res", 32'(want.done), 32'(done_res_o));
      end
    end
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/bnwq_pkg.sv
rtl/bnwq_front.sv
rtl/bnwq_back.sv
rtl/buffered_nvm_write_queue_top.sv
tb/buffered_nvm_write_queue_top_tb.sv
